### rtl/qidt_pkg.sv
// Shared types and constants for the query ID translation table.
// No dependencies; every other file but qidt_ram imports this package.
package qidt_pkg;

  // Field widths
  localparam int ID_W       = 16;
  localparam int ADDR_W     = 48;
  localparam int TIME_W     = 32;
  localparam int NEWID_W    = 9;
  localparam int STATUS_W   = 2;
  localparam int EXP_W      = 16;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_EXPIRY = 1'b0;  // top paddr bit value selecting expiry_seconds
  localparam logic [EXP_W-1:0] EXPIRY_RESET = 16'd1000;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ID    = 2'd3;

  // Input modes
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Classified command
  typedef enum logic [1:0] {
    K_ALLOC   = 2'd0,
    K_RELEASE = 2'd1,
    K_BADID   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [ID_W-1:0]     client_id;
    logic [ADDR_W-1:0]   peer_addr;
    logic [TIME_W-1:0]   now_seconds;
    logic [ID_W-1:0]     slot_idx;     // relay ID minus one, release only
  } qentry_t;

  // One table slot as stored in the slot RAM
  typedef struct packed {
    logic [ID_W-1:0]     orig_id;
    logic [ADDR_W-1:0]   peer_addr;
    logic [TIME_W-1:0]   deadline;
    logic                done;
  } slot_t;

endpackage

### rtl/qidt_ifs.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on qidt_pkg for field widths.
interface qidt_req_if import qidt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [ID_W-1:0]     client_id;
  logic [ADDR_W-1:0]   peer_addr;
  logic [TIME_W-1:0]   now_seconds;
  logic [ID_W-1:0]     relay_id;

  modport source (output valid, mode, client_id, peer_addr, now_seconds, relay_id,
                  input ready);
  modport sink   (input valid, mode, client_id, peer_addr, now_seconds, relay_id,
                  output ready);
endinterface

interface qidt_rsp_if import qidt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NEWID_W-1:0]  new_id;
  logic [ID_W-1:0]     orig_id;
  logic [ADDR_W-1:0]   orig_addr;

  modport source (output valid, status, new_id, orig_id, orig_addr, input ready);
  modport sink   (input valid, status, new_id, orig_id, orig_addr, output ready);
endinterface

### rtl/qidt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qidt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/qidt_queue.sv
// Short command FIFO between the classifying front and the table engine.
// Depends on qidt_pkg for the entry type and depth.
module qidt_queue import qidt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_data,
  input  logic    pop,
  output qentry_t head,
  output logic    full,
  output logic    empty
);

  qentry_t           q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not advance on push");
`endif

endmodule

### rtl/qidt_front.sv
// Request front end: takes transfers from the input channel, classifies them
// and pushes commands into the queue. Depends on qidt_pkg and qidt_req_if.
module qidt_front import qidt_pkg::*; #(
  parameter int SLOTS = 256
) (
  qidt_req_if.sink in_ch,
  input  logic     clearing,
  input  logic     q_full,
  output logic     push,
  output qentry_t  push_data
);

  logic id_bad;

  // no transfers during the post-reset clearing pass or with a full queue
  assign in_ch.ready = !q_full && !clearing;
  assign push        = in_ch.valid && in_ch.ready;

  // relay ID zero or past the last slot is out of range
  assign id_bad = (in_ch.relay_id == '0) ||
                  ({1'b0, in_ch.relay_id} > (ID_W+1)'(SLOTS));

  always_comb begin
    push_data.client_id   = in_ch.client_id;
    push_data.peer_addr   = in_ch.peer_addr;
    push_data.now_seconds = in_ch.now_seconds;
    push_data.slot_idx    = in_ch.relay_id - ID_W'(1);
    if (in_ch.mode == MODE_ALLOC) begin
      push_data.kind = K_ALLOC;
    end else if (id_bad) begin
      push_data.kind = K_BADID;
    end else begin
      push_data.kind = K_RELEASE;
    end
  end

endmodule

### rtl/qidt_engine.sv
// Table engine: owns the slot RAM, runs the clearing pass, the allocate scan
// and release, and holds the response register. Depends on qidt_pkg,
// qidt_rsp_if and qidt_ram.
module qidt_engine import qidt_pkg::*; #(
  parameter int SLOTS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [EXP_W-1:0] expiry,
  input  logic             q_empty,
  input  qentry_t          q_head,
  output logic             pop,
  output logic             clearing,
  qidt_rsp_if.source       out_ch
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_RLS   = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [IW-1:0]       clr_idx_r, clr_idx_nxt;
  logic [IW-1:0]       chk_idx_r, chk_idx_nxt;
  qentry_t             cur_r, cur_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [NEWID_W-1:0]  res_new_id_r, res_new_id_nxt;
  logic [ID_W-1:0]     res_orig_id_r, res_orig_id_nxt;
  logic [ADDR_W-1:0]   res_orig_addr_r, res_orig_addr_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [NEWID_W-1:0]  out_new_id_r;
  logic [ID_W-1:0]     out_orig_id_r;
  logic [ADDR_W-1:0]   out_orig_addr_r;
  logic                out_load;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  slot_t               ram_wdata;
  logic [IW-1:0]       ram_raddr;
  slot_t               ram_rdata;

  logic [IW:0]         slot_num;
  logic                reusable;
  logic                id_ok;

  qidt_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign clearing = (state_r == S_CLEAR);

  // slot test for the entry under the scan
  assign slot_num = {1'b0, chk_idx_r} + (IW+1)'(1);
  assign reusable = ram_rdata.done ||
                    ((ram_rdata.deadline != '0) && (ram_rdata.deadline < cur_r.now_seconds));
  assign id_ok    = ((ID_W+1)'(slot_num) != {1'b0, cur_r.client_id});

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    clr_idx_nxt       = clr_idx_r;
    chk_idx_nxt       = chk_idx_r;
    cur_nxt           = cur_r;
    res_status_nxt    = res_status_r;
    res_new_id_nxt    = res_new_id_r;
    res_orig_id_nxt   = res_orig_id_r;
    res_orig_addr_nxt = res_orig_addr_r;
    pop               = 1'b0;
    out_load          = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = chk_idx_r;
    ram_wdata         = ram_rdata;
    ram_raddr         = chk_idx_r + IW'(1);

    unique case (state_r)
      S_CLEAR: begin
        ram_we                = 1'b1;
        ram_waddr             = clr_idx_r;
        ram_wdata             = '0;
        ram_wdata.done        = 1'b1;
        clr_idx_nxt           = clr_idx_r + IW'(1);
        if (clr_idx_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cur_nxt = q_head;
          case (q_head.kind)
            K_ALLOC: begin
              ram_raddr   = '0;
              chk_idx_nxt = '0;
              state_nxt   = S_SCAN;
            end
            K_RELEASE: begin
              ram_raddr = q_head.slot_idx[IW-1:0];
              state_nxt = S_RLS;
            end
            default: begin
              res_status_nxt    = ST_BAD_ID;
              res_new_id_nxt    = '0;
              res_orig_id_nxt   = '0;
              res_orig_addr_nxt = '0;
              state_nxt         = S_RESP;
            end
          endcase
        end
      end

      // one slot per cycle; the read for the next slot is already in flight
      S_SCAN: begin
        if (reusable && id_ok) begin
          ram_we                = 1'b1;
          ram_waddr             = chk_idx_r;
          ram_wdata.orig_id     = cur_r.client_id;
          ram_wdata.peer_addr   = cur_r.peer_addr;
          ram_wdata.deadline    = cur_r.now_seconds + TIME_W'(expiry);
          ram_wdata.done        = 1'b0;
          res_status_nxt        = ST_ALLOCATED;
          res_new_id_nxt        = NEWID_W'(slot_num);
          res_orig_id_nxt       = '0;
          res_orig_addr_nxt     = '0;
          state_nxt             = S_RESP;
        end else if (chk_idx_r == LAST) begin
          res_status_nxt    = ST_FULL;
          res_new_id_nxt    = '0;
          res_orig_id_nxt   = '0;
          res_orig_addr_nxt = '0;
          state_nxt         = S_RESP;
        end else begin
          chk_idx_nxt = chk_idx_r + IW'(1);
        end
      end

      // mark the slot done, return what it holds
      S_RLS: begin
        ram_we            = 1'b1;
        ram_waddr         = cur_r.slot_idx[IW-1:0];
        ram_wdata         = ram_rdata;
        ram_wdata.done    = 1'b1;
        res_status_nxt    = ST_RELEASED;
        res_new_id_nxt    = '0;
        res_orig_id_nxt   = ram_rdata.orig_id;
        res_orig_addr_nxt = ram_rdata.peer_addr;
        state_nxt         = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // response register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_idx_r       <= chk_idx_nxt;
    cur_r           <= cur_nxt;
    res_status_r    <= res_status_nxt;
    res_new_id_r    <= res_new_id_nxt;
    res_orig_id_r   <= res_orig_id_nxt;
    res_orig_addr_r <= res_orig_addr_nxt;
    if (out_load) begin
      out_status_r    <= res_status_r;
      out_new_id_r    <= res_new_id_r;
      out_orig_id_r   <= res_orig_id_r;
      out_orig_addr_r <= res_orig_addr_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.new_id    = out_new_id_r;
  assign out_ch.orig_id   = out_orig_id_r;
  assign out_ch.orig_addr = out_orig_addr_r;

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == S_IDLE)
    else $error("command popped outside idle");
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> chk_idx_r <= LAST)
    else $error("scan index past last slot");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |-> !ram_we)
    else $error("slot RAM written while idle or responding");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("response loaded but not presented");
`endif

endmodule

### rtl/query_id_translation_table.sv
// Query ID translation table. From accept to response valid: an allocate is popped,
// scans 1..SLOTS slots, one slot RAM read per cycle, and loads its response; a release
// is popped, read and marked done; a bad relay ID is popped. The engine holds one item
// at a time (pop, work, response load); two more wait in the command queue. Reset: a
// clearing pass writes every slot free with in_ch.ready low; config writes are taken
// throughout. Depends on qidt_pkg, qidt_ifs, front/queue/engine.
module query_id_translation_table import qidt_pkg::*; #(
  parameter int SLOTS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  qidt_req_if.sink              in_ch,
  qidt_rsp_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [EXP_W-1:0] expiry_r, expiry_nxt;
  logic             cfg_wr;
  logic             clearing;
  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  qentry_t          push_data;
  qentry_t          q_head;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    expiry_nxt = expiry_r;
    if (cfg_wr && (paddr[CFG_ADDR_W-1] == REG_EXPIRY)) begin
      expiry_nxt = pwdata[EXP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= EXPIRY_RESET;
    end else begin
      expiry_r <= expiry_nxt;
    end
  end

  assign prdata = (paddr[CFG_ADDR_W-1] == REG_EXPIRY) ?
                  {{(CFG_DATA_W-EXP_W){1'b0}}, expiry_r} : '0;

  qidt_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .in_ch     (in_ch),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  qidt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  qidt_engine #(
    .SLOTS (SLOTS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .expiry   (expiry_r),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .pop      (pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule
